/* hdl/crd_pkg.sv */
// Shared types and constants for the checksummed record deframer.
package crd_pkg;

    localparam int unsigned RECORDS_PER_FRAME = 2;
    localparam int unsigned STORE_ROWS = 2;
    localparam int unsigned REC_CNT_W = $clog2(RECORDS_PER_FRAME + 1);

    localparam logic [7:0] HEADER_RESET = 8'hFF;
    localparam logic [7:0] START_RESET  = 8'h02;

    localparam int unsigned PADDR_W = 3;
    localparam logic REG_HEADER = 1'b0;
    localparam logic REG_START  = 1'b1;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_START   = 2'd1,
        PH_RECORDS = 2'd2,
        PH_CHECK   = 2'd3
    } t_phase;

    typedef struct packed {
        logic [7:0] header_byte;
        logic [7:0] start_byte;
    } t_crd_cfg;

endpackage

/* hdl/crd_cfg_regs.sv */
// APB register file holding the header and start byte values.
module crd_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [crd_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output crd_pkg::t_crd_cfg           o_cfg
);

    logic [7:0] r_header_byte;
    logic [7:0] r_start_byte;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_byte <= crd_pkg::HEADER_RESET;
            r_start_byte  <= crd_pkg::START_RESET;
        end else if (wr_en) begin
            if (paddr[2] == crd_pkg::REG_HEADER) begin
                r_header_byte <= pwdata[7:0];
            end else begin
                r_start_byte <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == crd_pkg::REG_HEADER) begin
            prdata = {24'd0, r_header_byte};
        end else begin
            prdata = {24'd0, r_start_byte};
        end
    end

    assign o_cfg.header_byte = r_header_byte;
    assign o_cfg.start_byte  = r_start_byte;

endmodule

/* hdl/crd_parser.sv */
// Frame parser: phase tracking, checksum, word store and result register.
module crd_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  crd_pkg::t_crd_cfg i_cfg,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_rx_byte,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [31:0]       o_word_zero,
    output logic [31:0]       o_word_one,
    output logic              o_frame_status
);

    crd_pkg::t_phase                r_phase, n_phase;
    logic [2:0]                     r_byte_pos, n_byte_pos;
    logic [crd_pkg::REC_CNT_W-1:0]  r_rec_cnt, n_rec_cnt;
    logic [7:0]                     r_sum, n_sum;
    logic [7:0]                     r_cur_id, n_cur_id;
    logic [31:0]                    r_store [crd_pkg::STORE_ROWS];
    logic [31:0]                    n_store [crd_pkg::STORE_ROWS];
    logic                           r_out_valid, n_out_valid;
    logic [31:0]                    r_word_zero, n_word_zero;
    logic [31:0]                    r_word_one, n_word_one;
    logic                           r_status, n_status;
    logic                           accept;
    logic                           ok;
    logic [31:0]                    upd_word;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign ok         = (i_rx_byte == r_sum);

    // Merge the incoming byte into the addressed row, big-endian.
    always_comb begin
        upd_word = r_store[r_cur_id[0]];
        case (r_byte_pos)
            3'd1:    upd_word[31:24] = i_rx_byte;
            3'd2:    upd_word[23:16] = i_rx_byte;
            3'd3:    upd_word[15:8]  = i_rx_byte;
            3'd4:    upd_word[7:0]   = i_rx_byte;
            default: upd_word        = r_store[r_cur_id[0]];
        endcase
    end

    always_comb begin
        n_phase     = r_phase;
        n_byte_pos  = r_byte_pos;
        n_rec_cnt   = r_rec_cnt;
        n_sum       = r_sum;
        n_cur_id    = r_cur_id;
        n_store     = r_store;
        n_out_valid = r_out_valid && i_out_stall;
        n_word_zero = r_word_zero;
        n_word_one  = r_word_one;
        n_status    = r_status;
        if (accept) begin
            case (r_phase)
                crd_pkg::PH_HUNT: begin
                    if (i_rx_byte == i_cfg.header_byte) begin
                        n_phase = crd_pkg::PH_START;
                    end
                end
                crd_pkg::PH_START: begin
                    if (i_rx_byte == i_cfg.start_byte) begin
                        n_sum      = i_cfg.header_byte + i_cfg.start_byte;
                        n_byte_pos = 3'd0;
                        n_rec_cnt  = '0;
                        n_phase    = crd_pkg::PH_RECORDS;
                    end else begin
                        n_phase = crd_pkg::PH_HUNT;
                    end
                end
                crd_pkg::PH_RECORDS: begin
                    n_sum = r_sum + i_rx_byte;
                    if (r_byte_pos == 3'd0) begin
                        n_cur_id = i_rx_byte;
                    end else if (r_cur_id[7:1] == 7'd0) begin
                        n_store[r_cur_id[0]] = upd_word;
                    end
                    if (r_byte_pos >= 3'd4) begin
                        n_byte_pos = 3'd0;
                        n_rec_cnt  = r_rec_cnt + 1'b1;
                        if (r_rec_cnt >= crd_pkg::REC_CNT_W'(crd_pkg::RECORDS_PER_FRAME - 1))
                        begin
                            n_phase = crd_pkg::PH_CHECK;
                        end
                    end else begin
                        n_byte_pos = r_byte_pos + 3'd1;
                    end
                end
                crd_pkg::PH_CHECK: begin
                    n_out_valid = 1'b1;
                    n_word_zero = ok ? r_store[0] : 32'd0;
                    n_word_one  = ok ? r_store[1] : 32'd0;
                    n_status    = !ok;
                    n_phase     = crd_pkg::PH_HUNT;
                    n_byte_pos  = 3'd0;
                    n_rec_cnt   = '0;
                    n_sum       = 8'd0;
                end
                default: begin
                    n_phase = crd_pkg::PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= crd_pkg::PH_HUNT;
            r_byte_pos  <= 3'd0;
            r_rec_cnt   <= '0;
            r_sum       <= 8'd0;
            r_cur_id    <= 8'd0;
            r_store[0]  <= 32'd0;
            r_store[1]  <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_byte_pos  <= n_byte_pos;
            r_rec_cnt   <= n_rec_cnt;
            r_sum       <= n_sum;
            r_cur_id    <= n_cur_id;
            r_store     <= n_store;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word_zero <= n_word_zero;
        r_word_one  <= n_word_one;
        r_status    <= n_status;
    end

    assign o_out_valid    = r_out_valid;
    assign o_word_zero    = r_word_zero;
    assign o_word_one     = r_word_one;
    assign o_frame_status = r_status;

endmodule

/* hdl/checksummed_record_deframer_unit.sv */
// Top level of the checksummed record deframer.
// Takes one received byte per cycle. A frame is a header byte, a start byte,
// RECORDS_PER_FRAME records of an id byte and a big-endian 32-bit word, and
// an 8-bit additive checksum over all bytes before it. Each byte is consumed
// in the cycle it is accepted by a single state update; the checksum byte
// produces one item in the result register on the following cycle, with both
// stored words and status 0, or zero words and status 1 on a mismatch. The
// input stalls only while that result register holds an item that is itself
// stalled. Ids beyond the two store rows write nothing but still count in
// the checksum; rows keep their words across frames.
module checksummed_record_deframer_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [crd_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [7:0]                  i_rx_byte,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [31:0]                 o_word_zero,
    output logic [31:0]                 o_word_one,
    output logic                        o_frame_status
);

    crd_pkg::t_crd_cfg cfg;

    crd_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    crd_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_word_zero    (o_word_zero),
        .o_word_one     (o_word_one),
        .o_frame_status (o_frame_status)
    );

endmodule
